// File: design/pebr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pebr_pkg;

    localparam int DETECTOR_COUNT_DEF = 128;
    localparam int SUM_WIDTH_DEF      = 24;
    localparam int SAMPLE_WIDTH_DEF   = 14;

    localparam int FL_W       = 12;
    localparam int MASK_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int DET_ID_W   = 7;
    localparam int PZ_W       = 16;
    localparam int GAIN_W     = 20;
    localparam int OFF_W      = 20;
    localparam int AVG_W      = 24;
    localparam int OUT_W      = 24;

    // shared divider: signed numerator / signed divisor widths
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 40;

    localparam logic [FL_W-1:0]   FL_RESET = 12'd400;
    localparam logic [PZ_W-1:0]   PZ_ONE   = 16'd32768;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 20'd65536;
    localparam logic [OFF_W-1:0]  OFF_ZERO = '0;

    localparam int PZ_FRAC   = 15;
    localparam int BASE_FRAC = 8;
    localparam int GAIN_FRAC = 16;
    localparam int GAIN_HALF = 32768;
    localparam int EU_SHIFT  = 19;

    localparam int BASE1_LIMIT     = 40000 * 256;
    localparam int SUM_DIFF_MIN    = 200;
    localparam int RATIO_B1        = 20;
    localparam int RATIO_B2_LO     = 19;
    localparam int RATIO_B2_HI     = 21;
    localparam int AVG_KEEP        = 99;
    localparam int AVG_DIV         = 100;
    localparam int ENERGY_DISABLED = -16;

    // running average: round((99*avg + base1) / 100) by reciprocal multiply,
    // exact for any 32-bit dividend
    localparam int              AVG_HALF        = AVG_DIV / 2;
    localparam int              AVG_Y_W         = 32;
    localparam logic [AVG_Y_W-1:0] AVG_RECIP    = 32'd1374389535;
    localparam int              AVG_RECIP_SHIFT = 37;

    localparam logic ACT_LOAD = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_LENGTH = 2'd0,
        CFG_MASK_LOW      = 2'd1,
        CFG_MASK_HIGH     = 2'd2
    } pebr_cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_CHECK,
        S_AVG_SUM,
        S_AVG_MUL,
        S_EMUL1,
        S_EMUL2,
        S_GAIN,
        S_GMUL,
        S_FIN,
        S_OUT
    } pebr_state_t;

    typedef enum logic [1:0] {
        DIV_B1,
        DIV_B2,
        DIV_EU
    } pebr_div_op_t;

    // saturate a wide signed value into the 24-bit result range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [DIV_NW:0] v);
        logic signed [DIV_NW:0] hi;
        logic signed [DIV_NW:0] lo;
        hi = (DIV_NW+1)'((2 ** (OUT_W - 1)) - 1);
        lo = -(DIV_NW+1)'(2 ** (OUT_W - 1));
        if (v > hi) begin
            sat_out = hi[OUT_W-1:0];
        end
        else if (v < lo) begin
            sat_out = lo[OUT_W-1:0];
        end
        else begin
            sat_out = v[OUT_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: design/pulse_energy_baseline_restore_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Baseline-restoring energy core for a detector array.
// Channels: a configuration write channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) sets filter length and the two 64-bit enable masks; it is always
// ready; the user must write it only while the core is idle, and the core
// does not enforce this. Input transactions (in_valid/in_ready) carry either
// a hit or a calibration load for one detector; each produces exactly one
// output transaction (out_valid/out_ready). Throughput: one transaction at a
// time. A hit runs through the single shared bit-serial divider, three
// quotients per hit and one on a divide error. The core is ready for the next
// input in the cycle after the result register loads. Per-detector state
// lives in two block RAMs (running baseline and calibration); a row with its
// valid bit clear reads as its reset value. Reset clears the configuration
// to its defaults and all valid bits at once, so the core takes traffic in
// the first cycle after reset.
// Stall: the result sits in an output register; the core takes the next input
// while it waits and holds the following result until the register frees.
module pulse_energy_baseline_restore_core #(
    parameter int DETECTOR_COUNT = pebr_pkg::DETECTOR_COUNT_DEF,
    parameter int SUM_WIDTH      = pebr_pkg::SUM_WIDTH_DEF,
    parameter int SAMPLE_WIDTH   = pebr_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pebr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pebr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                action,
    input  wire logic [pebr_pkg::DET_ID_W-1:0]       detector_id,
    input  wire logic [SUM_WIDTH-1:0]                sum_early,
    input  wire logic [SUM_WIDTH-1:0]                sum_late,
    input  wire logic [SAMPLE_WIDTH-1:0]             first_window_begin,
    input  wire logic [SAMPLE_WIDTH-1:0]             first_window_end,
    input  wire logic [SAMPLE_WIDTH-1:0]             second_window_begin,
    input  wire logic [SAMPLE_WIDTH-1:0]             second_window_end,
    input  wire logic                                first_in_event,
    input  wire logic [pebr_pkg::PZ_W-1:0]           cal_pole_zero,
    input  wire logic [pebr_pkg::GAIN_W-1:0]         cal_gain,
    input  wire logic signed [pebr_pkg::OFF_W-1:0]   cal_offset,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [pebr_pkg::OUT_W-1:0]        energy,
    output logic signed [pebr_pkg::OUT_W-1:0]        energy_uncalibrated,
    output logic signed [pebr_pkg::OUT_W-1:0]        event_baseline,
    output logic [pebr_pkg::AVG_W-1:0]               average_baseline,
    output logic                                     detector_enabled,
    output logic                                     baseline_updated,
    output logic                                     divide_error
);

    import pebr_pkg::*;

    localparam int SW     = SUM_WIDTH;
    localparam int MW     = SAMPLE_WIDTH;
    localparam int SLOT_W = $clog2(DETECTOR_COUNT);
    localparam int CAL_W  = PZ_W + GAIN_W + OFF_W;
    localparam int Q_W    = PZ_W + AVG_W + 3;
    localparam int QM_W   = Q_W + FL_W + 1;
    localparam int G_W    = OUT_W + GAIN_W + 1;
    localparam int CMP_W  = DIV_NW + 6;

    // control
    pebr_state_t  state_reg, state_next;
    pebr_div_op_t sel_reg, sel_next;

    logic [FL_W-1:0]           fl_reg;
    logic [MASK_W-1:0]         mask_lo_reg;
    logic [MASK_W-1:0]         mask_hi_reg;
    logic [DETECTOR_COUNT-1:0] avg_vld_reg;
    logic [DETECTOR_COUNT-1:0] cal_vld_reg;
    logic                      out_valid_reg;

    // captured transaction
    logic                     act_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [SW-1:0]            s1_reg, s2_reg;
    logic [MW-1:0]            m1b_reg, m1e_reg, m2b_reg, m2e_reg;
    logic                     fie_reg;
    logic [PZ_W-1:0]          cpz_reg;
    logic [GAIN_W-1:0]        cgain_reg;
    logic signed [OFF_W-1:0]  coff_reg;

    // working registers
    logic [AVG_W-1:0]         avg_cur_reg;
    logic [PZ_W-1:0]          pz_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [OFF_W-1:0]  off_reg;
    logic                     en_reg;
    logic signed [SW:0]       dsum_reg;
    logic signed [DIV_DW-1:0] d1_reg, d2_reg;
    logic [SW+MW-1:0]         p1_reg, p2_reg;
    logic [2*MW-1:0]          p3_reg, p4_reg;
    logic signed [DIV_NW-1:0] n1_reg, n2_reg;
    logic                     err_reg;
    logic                     upd_reg;
    logic signed [DIV_NW:0]   b1_reg, b2_reg, eu_reg;
    logic [AVG_Y_W-1:0]       avg_y_reg;
    logic signed [Q_W-1:0]    q_reg;
    logic signed [DIV_NW-1:0] a_reg;
    logic signed [QM_W-1:0]   qm_reg;
    logic signed [OUT_W-1:0]  eus_reg;
    logic signed [G_W-1:0]    g_reg;
    logic signed [OUT_W-1:0]  e_reg;

    // result register
    logic signed [OUT_W-1:0]  energy_reg, eu_out_reg, evb_reg;
    logic [AVG_W-1:0]         avgo_reg;
    logic                     en_out_reg, upd_out_reg, err_out_reg;

    // combinational
    logic                     accept;
    logic                     out_free;
    logic                     out_load;
    logic [SLOT_W-1:0]        slot_in;
    logic [FL_W-1:0]          m_val;
    logic signed [FL_W:0]     m_s;
    logic [(2*MASK_W)-1:0]    mask_all;
    logic [AVG_W-1:0]         avg_rdata, avg_rd_val, avg_wdata;
    logic                     avg_we;
    logic [CAL_W-1:0]         cal_rdata, cal_rd_val;
    logic                     cal_we;
    logic signed [SW:0]       dsum;
    logic signed [MW:0]       mdb;
    logic signed [FL_W+MW+1:0] mprod;
    logic signed [MW+1:0]     d2n;
    logic                     err_now;
    logic                     chk_ok;
    logic signed [CMP_W-1:0]  b1_x, b2_x;
    logic [2*AVG_Y_W-1:0]     avg_prod;
    logic [AVG_W-1:0]         avg_quo;
    logic signed [PZ_W+1:0]   pzc;
    logic [SW+PZ_W-1:0]       s1pz;
    logic signed [DIV_NW-1:0] a_val;
    logic [G_W-1:0]           g_mag, g_rnd;
    logic signed [DIV_NW:0]   g_sum;
    logic                     div_start, div_done;
    logic signed [DIV_NW-1:0] div_num;
    logic signed [DIV_DW-1:0] div_den;
    logic signed [DIV_NW:0]   div_quo;

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign slot_in   = ({1'b0, detector_id} < (DET_ID_W+1)'(DETECTOR_COUNT))
                       ? detector_id[SLOT_W-1:0] : '0;
    assign m_val     = (fl_reg == '0) ? FL_W'(1) : fl_reg;
    assign m_s       = $signed({1'b0, m_val});
    assign mask_all  = {mask_hi_reg, mask_lo_reg};

    // never-written rows read as their reset values
    assign avg_rd_val = avg_vld_reg[slot_reg] ? avg_rdata : '0;
    assign cal_rd_val = cal_vld_reg[slot_reg] ? cal_rdata : {PZ_ONE, GAIN_ONE, OFF_ZERO};

    // baseline divisors
    assign dsum  = $signed({1'b0, s2_reg}) - $signed({1'b0, s1_reg});
    assign mdb   = $signed({1'b0, m2b_reg}) - $signed({1'b0, m1b_reg});
    assign mprod = m_s * mdb;
    assign d2n   = ($signed({2'b0, m2b_reg}) - $signed({2'b0, m2e_reg}))
                 - ($signed({2'b0, m1b_reg}) - $signed({2'b0, m1e_reg}));
    assign err_now = (d1_reg == '0) || (d2_reg == '0);

    // update test: 0 < b1 < limit, sum gap, first in event, ratio window
    assign b1_x   = CMP_W'(b1_reg);
    assign b2_x   = CMP_W'(b2_reg);
    assign chk_ok = !b1_reg[DIV_NW] && (b1_reg != '0)
                 && (b1_reg < (DIV_NW+1)'(BASE1_LIMIT))
                 && (dsum_reg > (SW+1)'(SUM_DIFF_MIN))
                 && fie_reg
                 && !b2_reg[DIV_NW] && (b2_reg != '0)
                 && (b1_x * CMP_W'(RATIO_B1) > b2_x * CMP_W'(RATIO_B2_LO))
                 && (b1_x * CMP_W'(RATIO_B1) < b2_x * CMP_W'(RATIO_B2_HI));

    // running average quotient: rounded sum times reciprocal, take high bits
    assign avg_prod = avg_y_reg * AVG_RECIP;
    assign avg_quo  = avg_prod[AVG_RECIP_SHIFT +: AVG_W];

    // energy numerator pieces
    assign pzc   = $signed({2'b0, PZ_ONE}) - $signed({2'b0, pz_reg});
    assign s1pz  = s1_reg * pz_reg;
    assign a_val = ($signed(DIV_NW'(s2_reg) << PZ_FRAC) - $signed(DIV_NW'(s1pz)))
                   <<< BASE_FRAC;

    // gain product rounded back to Q.4, then offset
    assign g_mag = g_reg[G_W-1] ? G_W'(-g_reg) : G_W'(g_reg);
    assign g_rnd = (g_mag + G_W'(GAIN_HALF)) >> GAIN_FRAC;
    assign g_sum = (g_reg[G_W-1] ? -$signed((DIV_NW+1)'(g_rnd))
                                 : $signed((DIV_NW+1)'(g_rnd)))
                 + (DIV_NW+1)'(off_reg);

    // divider operand select
    always_comb
    begin
        case (sel_reg)
            DIV_B1:
            begin
                div_num = n1_reg;
                div_den = d1_reg;
            end
            DIV_B2:
            begin
                div_num = n2_reg;
                div_den = d2_reg;
            end
            default:
            begin
                div_num = a_reg - DIV_NW'(qm_reg);
                div_den = $signed(DIV_DW'(m_val) << EU_SHIFT);
            end
        endcase
    end

    pebr_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    pebr_ram #(
        .WIDTH (AVG_W),
        .DEPTH (DETECTOR_COUNT)
    ) u_avg_ram (
        .clk   (clk),
        .we    (avg_we),
        .waddr (slot_reg),
        .wdata (avg_wdata),
        .raddr (slot_in),
        .rdata (avg_rdata)
    );

    pebr_ram #(
        .WIDTH (CAL_W),
        .DEPTH (DETECTOR_COUNT)
    ) u_cal_ram (
        .clk   (clk),
        .we    (cal_we),
        .waddr (slot_reg),
        .wdata ({cpz_reg, cgain_reg, coff_reg}),
        .raddr (slot_in),
        .rdata (cal_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = (act_reg == ACT_LOAD) ? S_OUT : S_MUL;
            end
            S_MUL:
            begin
                if (err_now)
                begin
                    state_next = S_EMUL1;
                end
                else
                begin
                    sel_next   = DIV_B1;
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (sel_reg)
                        DIV_B1:
                        begin
                            sel_next   = DIV_B2;
                            state_next = S_DIV_GO;
                        end
                        DIV_B2:  state_next = S_CHECK;
                        default: state_next = S_GAIN;
                    endcase
                end
            end
            S_CHECK:
            begin
                if (chk_ok && (avg_cur_reg != '0))
                begin
                    state_next = S_AVG_SUM;
                end
                else
                begin
                    state_next = S_EMUL1;
                end
            end
            S_AVG_SUM:
            begin
                state_next = S_AVG_MUL;
            end
            S_AVG_MUL:
            begin
                state_next = S_EMUL1;
            end
            S_EMUL1:
            begin
                state_next = S_EMUL2;
            end
            S_EMUL2:
            begin
                sel_next   = DIV_EU;
                state_next = S_DIV_GO;
            end
            S_GAIN:
            begin
                state_next = S_GMUL;
            end
            S_GMUL:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        avg_we    = 1'b0;
        avg_wdata = b1_reg[AVG_W-1:0];
        cal_we    = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_PREP:
            begin
                cal_we = (act_reg == ACT_LOAD);
            end
            S_DIV_GO:
            begin
                div_start = 1'b1;
            end
            S_CHECK:
            begin
                // empty slot: seed with this hit's estimate
                avg_we = chk_ok && (avg_cur_reg == '0);
            end
            S_AVG_MUL:
            begin
                avg_we    = 1'b1;
                avg_wdata = avg_quo;
            end
            S_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // control registers, configuration and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= DIV_B1;
            fl_reg        <= FL_RESET;
            mask_lo_reg   <= '1;
            mask_hi_reg   <= '1;
            avg_vld_reg   <= '0;
            cal_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_FILTER_LENGTH: fl_reg      <= cfg_data[FL_W-1:0];
                    CFG_MASK_LOW:      mask_lo_reg <= cfg_data[MASK_W-1:0];
                    CFG_MASK_HIGH:     mask_hi_reg <= cfg_data[MASK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (avg_we)
            begin
                avg_vld_reg[slot_reg] <= 1'b1;
            end
            if (cal_we)
            begin
                cal_vld_reg[slot_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_reg   <= action;
                    slot_reg  <= slot_in;
                    s1_reg    <= sum_early;
                    s2_reg    <= sum_late;
                    m1b_reg   <= first_window_begin;
                    m1e_reg   <= first_window_end;
                    m2b_reg   <= second_window_begin;
                    m2e_reg   <= second_window_end;
                    fie_reg   <= first_in_event;
                    cpz_reg   <= cal_pole_zero;
                    cgain_reg <= cal_gain;
                    coff_reg  <= cal_offset;
                    upd_reg   <= 1'b0;
                    err_reg   <= 1'b0;
                end
            end
            S_PREP:
            begin
                avg_cur_reg <= avg_rd_val;
                {pz_reg, gain_reg, off_reg} <= cal_rd_val;
                en_reg   <= mask_all[slot_reg];
                dsum_reg <= dsum;
                d1_reg   <= DIV_DW'(dsum) - DIV_DW'(mprod);
                d2_reg   <= DIV_DW'(d2n);
                p1_reg   <= s2_reg * m1b_reg;
                p2_reg   <= s1_reg * m2b_reg;
                p3_reg   <= m1e_reg * m2b_reg;
                p4_reg   <= m1b_reg * m2e_reg;
            end
            S_MUL:
            begin
                n1_reg  <= ($signed(DIV_NW'(p1_reg)) - $signed(DIV_NW'(p2_reg))) <<< BASE_FRAC;
                n2_reg  <= ($signed(DIV_NW'(p3_reg)) - $signed(DIV_NW'(p4_reg))) <<< BASE_FRAC;
                err_reg <= err_now;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (sel_reg)
                        DIV_B1:  b1_reg <= div_quo;
                        DIV_B2:  b2_reg <= div_quo;
                        default: eu_reg <= div_quo;
                    endcase
                end
            end
            S_CHECK:
            begin
                upd_reg <= chk_ok;
                if (chk_ok && (avg_cur_reg == '0))
                begin
                    avg_cur_reg <= b1_reg[AVG_W-1:0];
                end
            end
            S_AVG_SUM:
            begin
                // base1 is below the update limit here, so 24 bits hold it
                avg_y_reg <= AVG_Y_W'(avg_cur_reg) * AVG_Y_W'(AVG_KEEP)
                           + AVG_Y_W'(b1_reg[AVG_W-1:0]) + AVG_Y_W'(AVG_HALF);
            end
            S_AVG_MUL:
            begin
                avg_cur_reg <= avg_quo;
            end
            S_EMUL1:
            begin
                q_reg <= pzc * $signed({1'b0, avg_cur_reg});
                a_reg <= a_val;
            end
            S_EMUL2:
            begin
                qm_reg <= q_reg * m_s;
            end
            S_GAIN:
            begin
                eus_reg <= sat_out(eu_reg);
            end
            S_GMUL:
            begin
                g_reg <= eus_reg * $signed({1'b0, gain_reg});
            end
            S_FIN:
            begin
                e_reg <= sat_out(g_sum);
            end
            default:
            begin
            end
        endcase
    end

    // result register: load the finished transaction, hold while stalled
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (act_reg == ACT_LOAD)
            begin
                energy_reg <= '0;
                eu_out_reg <= '0;
                evb_reg    <= '0;
            end
            else
            begin
                energy_reg <= en_reg ? e_reg : OUT_W'(ENERGY_DISABLED);
                eu_out_reg <= eus_reg;
                evb_reg    <= err_reg ? '0 : sat_out(b1_reg);
            end
            avgo_reg    <= avg_cur_reg;
            en_out_reg  <= en_reg;
            upd_out_reg <= upd_reg;
            err_out_reg <= err_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign energy              = energy_reg;
    assign energy_uncalibrated = eu_out_reg;
    assign event_baseline      = evb_reg;
    assign average_baseline    = avgo_reg;
    assign detector_enabled    = en_out_reg;
    assign baseline_updated    = upd_out_reg;
    assign divide_error        = err_out_reg;

endmodule
`default_nettype wire

// File: design/pebr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pebr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: design/pebr_div.sv
`timescale 1ns / 1ps
`default_nettype none
module pebr_div #(
    parameter int NW = pebr_pkg::DIV_NW,
    parameter int DW = pebr_pkg::DIV_DW
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [NW-1:0] num,
    input  wire logic signed [DW-1:0] den,
    output logic                      done,
    output logic signed [NW:0]        quo
);

    // restoring divide, one quotient bit per cycle, round half away from zero
    localparam int CW = $clog2(NW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] dvd_reg;

    logic [NW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [DW:0]   trial;
    logic          fits;
    logic [NW:0]   quo_mag;

    assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);
    assign trial   = {rem_reg, dvd_reg[NW-1]};
    assign fits    = trial >= {1'b0, den_reg};
    assign quo_mag = {1'b0, dvd_reg};
    assign quo     = neg_reg ? -$signed(quo_mag) : $signed(quo_mag);
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den_mag;
            neg_reg <= num[NW-1] ^ den[DW-1];
            dvd_reg <= num_mag + NW'(den_mag >> 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            dvd_reg <= {dvd_reg[NW-2:0], fits};
        end
    end

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import pebr_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    // one input transaction: a hit or a calibration load
    typedef struct {
        logic              act;
        logic [6:0]        det;
        logic [23:0]       s_early;
        logic [23:0]       s_late;
        logic [13:0]       w1b;
        logic [13:0]       w1e;
        logic [13:0]       w2b;
        logic [13:0]       w2e;
        logic              first;
        logic [15:0]       pz;
        logic [19:0]       gain;
        logic signed [19:0] offs;
    } hit_t;

    // one output transaction
    typedef struct {
        logic [23:0] e;
        logic [23:0] eu;
        logic [23:0] eb;
        logic [23:0] avg;
        logic        en;
        logic        upd;
        logic        derr;
    } energy_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [OUT_W-1:0] energy;
    logic signed [OUT_W-1:0] energy_uncalibrated;
    logic signed [OUT_W-1:0] event_baseline;
    logic [AVG_W-1:0] average_baseline;
    logic detector_enabled;
    logic baseline_updated;
    logic divide_error;

    hit_t cur = '{default: '0};

    pulse_energy_baseline_restore_core i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .action              (cur.act),
        .detector_id         (cur.det),
        .sum_early           (cur.s_early),
        .sum_late            (cur.s_late),
        .first_window_begin  (cur.w1b),
        .first_window_end    (cur.w1e),
        .second_window_begin (cur.w2b),
        .second_window_end   (cur.w2e),
        .first_in_event      (cur.first),
        .cal_pole_zero       (cur.pz),
        .cal_gain            (cur.gain),
        .cal_offset          (cur.offs),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .energy              (energy),
        .energy_uncalibrated (energy_uncalibrated),
        .event_baseline      (event_baseline),
        .average_baseline    (average_baseline),
        .detector_enabled    (detector_enabled),
        .baseline_updated    (baseline_updated),
        .divide_error        (divide_error)
    );

    always #2 clk = ~clk;

    // predictor copy of the registers and the per-detector tables
    logic [11:0]        flen;
    logic [63:0]        en_lo;
    logic [63:0]        en_hi;
    logic [23:0]        avg_tbl [128];
    logic [15:0]        pz_tbl [128];
    logic [19:0]        gain_tbl [128];
    logic signed [19:0] off_tbl [128];

    hit_t    pending_hits [$];
    energy_t expected_energies [$];
    int      failures = 0;
    int      cycles = 0;
    logic    in_fire = 1'b0;
    int      in_gap = 0;
    int      out_stall = 0;

    // append one transaction to the driver queue
    function automatic void enqueue_hit(input hit_t h);
        pending_hits.insert(pending_hits.size(), h);
    endfunction

    // divide, rounding to nearest with ties away from zero
    function automatic longint round_div(input longint n, input longint d);
        longint un;
        longint ud;
        longint q;
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = (un + ud / 2) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint clamp24(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint eff_len();
        return flen == 0 ? 1 : longint'(flen);
    endfunction

    // compute the result of one accepted transaction and advance the tables
    function automatic energy_t restore_energy(input hit_t h);
        energy_t r;
        int slot;
        logic en;
        longint s1, s2, a1, b1w, a2, b2w, m, d1, d2, bl1, bl2, p, av, num, eu, e;
        logic err;
        slot = int'(h.det);
        en = slot < 64 ? en_lo[slot] : en_hi[slot-64];
        r = '{default: '0};
        r.en = en;
        if (h.act == ACT_LOAD) begin
            pz_tbl[slot] = h.pz;
            gain_tbl[slot] = h.gain;
            off_tbl[slot] = h.offs;
            r.avg = avg_tbl[slot];
            return r;
        end
        s1 = longint'(h.s_early);
        s2 = longint'(h.s_late);
        a1 = longint'(h.w1b);
        b1w = longint'(h.w1e);
        a2 = longint'(h.w2b);
        b2w = longint'(h.w2e);
        m = eff_len();
        d1 = (s2 - s1) - m * (a2 - a1);
        d2 = (a2 - b2w) - (a1 - b1w);
        err = (d1 == 0) || (d2 == 0);
        bl1 = 0;
        if (!err) begin
            bl1 = round_div((s2 * a1 - s1 * a2) * 256, d1);
            bl2 = round_div((b1w * a2 - a1 * b2w) * 256, d2);
            if (bl1 > 0 && bl1 < BASE1_LIMIT && (s2 - s1) > SUM_DIFF_MIN && h.first &&
                bl2 > 0 && RATIO_B1 * bl1 > RATIO_B2_LO * bl2 &&
                RATIO_B1 * bl1 < RATIO_B2_HI * bl2) begin
                av = longint'(avg_tbl[slot]);
                av = av > 0 ? round_div(AVG_KEEP * av + bl1, AVG_DIV) : bl1;
                avg_tbl[slot] = av[23:0];
                r.upd = 1'b1;
            end
        end
        p = longint'(pz_tbl[slot]);
        av = longint'(avg_tbl[slot]);
        num = (s2 * 32768 - s1 * p) * 256 - (32768 - p) * av * m;
        eu = clamp24(round_div(num, m * 524288));
        e = clamp24(round_div(eu * longint'(gain_tbl[slot]), 65536) + longint'(off_tbl[slot]));
        if (!en) e = ENERGY_DISABLED;
        r.e = e[23:0];
        r.eu = eu[23:0];
        r.eb = err ? 24'd0 : 24'(clamp24(bl1));
        r.avg = av[23:0];
        r.derr = err;
        return r;
    endfunction

    // build a hit shaped like a real pulse: flat first window at baseline B,
    // decaying tail in the second window, sums consistent with the filter length
    function automatic hit_t pulse_hit();
        hit_t h;
        longint m, bmax, b, c, d, e1, e2;
        m = eff_len();
        bmax = 12000000 / m;
        if (bmax > 15000) bmax = 15000;
        if (bmax < 60) bmax = 60;
        b = $urandom_range(int'(bmax), 50);
        c = $urandom_range(300, 1);
        d = $urandom_range(int'(c) - 1, 0);
        e1 = $urandom_range(8, 0);
        e2 = e1 + m * c + $urandom_range(200000, 201);
        if (m * b + e2 > 16777215) e2 = 16777215 - m * b;
        h = '{default: '0};
        h.det = 7'($urandom);
        h.first = ($urandom_range(9, 0) != 0);
        h.w1b = 14'(b);
        h.w1e = 14'(b + (($urandom_range(3, 0) == 0) ? $urandom_range(2, 0) : 0));
        h.w2b = 14'(b + c);
        h.w2e = 14'(b + d);
        h.s_early = 24'(m * b + e1);
        h.s_late = 24'(m * b + e2);
        h.pz = 16'($urandom);
        h.gain = 20'($urandom);
        h.offs = 20'($urandom);
        return h;
    endfunction

    function automatic hit_t noise_hit();
        hit_t h;
        h.act = 1'($urandom);
        h.det = 7'($urandom);
        h.s_early = 24'($urandom);
        h.s_late = 24'($urandom);
        h.w1b = 14'($urandom);
        h.w1e = 14'($urandom);
        h.w2b = 14'($urandom);
        h.w2e = 14'($urandom);
        h.first = 1'($urandom);
        h.pz = 16'($urandom);
        h.gain = 20'($urandom);
        h.offs = 20'($urandom);
        return h;
    endfunction

    // driver: hold the item until accepted, then idle for a random gap
    always @(negedge clk) begin
        if (in_valid && !in_fire) begin
            // hold
        end
        else if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            in_valid <= 1'b0;
        end
        else if (pending_hits.size() > 0) begin
            cur <= pending_hits.pop_front();
            in_valid <= 1'b1;
            in_gap <= ($urandom_range(99, 0) < 65) ? 0 :
                      ($urandom_range(9, 0) < 8) ? $urandom_range(3, 1) : $urandom_range(80, 10);
        end
        else begin
            in_valid <= 1'b0;
        end
    end

    // receiver: stall at random, mostly short
    always @(negedge clk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
            if ($urandom_range(99, 0) < 25)
                out_stall <= ($urandom_range(9, 0) < 8) ? $urandom_range(3, 1) :
                             $urandom_range(120, 10);
        end
    end

    // monitor: predict on accepted inputs, compare accepted outputs
    always @(posedge clk) begin
        energy_t got;
        energy_t want;
        in_fire <= in_valid && in_ready;
        if (cfg_valid && cfg_ready) begin
            case (pebr_cfg_t'(cfg_index))
                CFG_FILTER_LENGTH: flen = cfg_data[11:0];
                CFG_MASK_LOW:      en_lo = cfg_data;
                CFG_MASK_HIGH:     en_hi = cfg_data;
                default: ;
            endcase
        end
        if (in_valid && in_ready)
            expected_energies.insert(expected_energies.size(), restore_energy(cur));
        if (out_valid && out_ready) begin
            got = '{energy, energy_uncalibrated, event_baseline, average_baseline,
                    detector_enabled, baseline_updated, divide_error};
            if (expected_energies.size() == 0) begin
                $error("unexpected output transaction");
                failures++;
            end
            else begin
                want = expected_energies.pop_front();
                if (got.e !== want.e) begin
                    $error("energy expected %0h actual %0h", want.e, got.e);
                    failures++;
                end
                if (got.eu !== want.eu) begin
                    $error("energy_uncalibrated expected %0h actual %0h", want.eu, got.eu);
                    failures++;
                end
                if (got.eb !== want.eb) begin
                    $error("event_baseline expected %0h actual %0h", want.eb, got.eb);
                    failures++;
                end
                if (got.avg !== want.avg) begin
                    $error("average_baseline expected %0h actual %0h", want.avg, got.avg);
                    failures++;
                end
                if (got.en !== want.en) begin
                    $error("detector_enabled expected %0b actual %0b", want.en, got.en);
                    failures++;
                end
                if (got.upd !== want.upd) begin
                    $error("baseline_updated expected %0b actual %0b", want.upd, got.upd);
                    failures++;
                end
                if (got.derr !== want.derr) begin
                    $error("divide_error expected %0b actual %0b", want.derr, got.derr);
                    failures++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input pebr_cfg_t idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_hits.size() > 0 || in_valid || expected_energies.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial begin
        hit_t h;
        logic [11:0] lens [6];
        logic [63:0] lo_masks [6];
        logic [63:0] hi_masks [6];
        int r;
        flen = FL_RESET;
        en_lo = '1;
        en_hi = '1;
        for (int i = 0; i < 128; i++) begin
            avg_tbl[i] = '0;
            pz_tbl[i] = PZ_ONE;
            gain_tbl[i] = GAIN_ONE;
            off_tbl[i] = OFF_ZERO;
        end
        lens = '{12'd400, 12'd1, 12'd4095, 12'd0, 12'($urandom_range(4095, 1)),
                 12'($urandom_range(600, 2))};
        lo_masks = '{'1, {$urandom, $urandom}, '0, '1, {$urandom, $urandom}, '1};
        hi_masks = '{'1, {$urandom, $urandom}, '0, '1, '1, {$urandom, $urandom}};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: run on reset defaults first
        h = '{default: '0};
        enqueue_hit(h);                                  // both divisors zero
        h = '{act: 1'b0, det: 7'd127, s_early: '1, s_late: '1, w1b: '1, w1e: '1,
              w2b: '1, w2e: '1, first: 1'b1, pz: '1, gain: '1, offs: '1};
        enqueue_hit(h);                                  // all fields at maximum
        for (int k = 0; k < 6; k++) enqueue_hit(pulse_hit());
        h = '{default: '0};
        h.act = ACT_LOAD;                                // pole-zero zero, max gain, min offset
        h.det = 7'd0;
        h.gain = '1;
        h.offs = 20'sh80000;
        enqueue_hit(h);
        h.det = 7'd127;                                  // max pole-zero, max offset
        h.pz = '1;
        h.gain = '0;
        h.offs = 20'sh7FFFF;
        enqueue_hit(h);
        for (int k = 0; k < 6; k++) begin
            h = pulse_hit();
            h.det = (k % 2 == 0) ? 7'd0 : 7'd127;
            h.first = 1'b1;
            enqueue_hit(h);
        end
        h = pulse_hit();
        h.first = 1'b0;                                  // not first in event
        enqueue_hit(h);
        h = pulse_hit();
        h.s_late = h.s_early + 24'd100;                  // sum difference too small
        enqueue_hit(h);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_FILTER_LENGTH, {$urandom, 20'($urandom), lens[ph]});
            write_reg(CFG_MASK_LOW, lo_masks[ph]);
            write_reg(CFG_MASK_HIGH, hi_masks[ph]);
            for (int k = 0; k < 315; k++) begin
                r = $urandom_range(99, 0);
                if (r < 10) begin
                    h = noise_hit();
                    h.act = ACT_LOAD;
                    if ($urandom_range(3, 0) == 0) h.pz = PZ_ONE - 16'($urandom_range(2000, 0));
                end
                else if (r < 70) begin
                    h = pulse_hit();
                end
                else if (r < 85) begin
                    h = noise_hit();
                    h.act = 1'b0;
                end
                else begin
                    // broken pulse: force one divisor to zero
                    h = pulse_hit();
                    if ($urandom_range(1, 0) == 0) begin
                        h.w2b = h.w1b;
                        h.w2e = h.w1e;
                    end
                    else begin
                        h.s_late = 24'(longint'(h.s_early) +
                                       eff_len() * (longint'(h.w2b) - longint'(h.w1b)));
                    end
                end
                enqueue_hit(h);
            end
            drain();
        end

        repeat (300) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
